// ===== hw/rtl/alist_pkg.sv =====
// Shared types and codes for the array list block.
// Used by alist_cell and array_list_insert_delete_search; no dependencies.
package alist_pkg;

    // Request types carried in the input item.
    localparam logic [2:0] REQ_INS_END   = 3'd0;
    localparam logic [2:0] REQ_INS_FRONT = 3'd1;
    localparam logic [2:0] REQ_INS_POS   = 3'd2;
    localparam logic [2:0] REQ_DEL_END   = 3'd3;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd4;
    localparam logic [2:0] REQ_DEL_POS   = 3'd5;
    localparam logic [2:0] REQ_SEARCH    = 3'd6;

    // Status codes carried in the result item.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    // Operations broadcast to every cell of the chain.
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_SRCH = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic        wave;
        logic [31:0] key;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/alist_cell.sv =====
// One cell of the list chain: holds one entry, its match flag and one stage
// of the search wave. Depends on alist_pkg.
module alist_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                       i_clk,
    input  alist_pkg::t_cell_ctrl      i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0] i_at,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  logic [31:0]                i_left_key,
    input  logic [31:0]                i_right_key,
    output logic [31:0]                o_key,
    input  logic                       i_prev_fnd,
    input  logic [$clog2(DEPTH)-1:0]   i_prev_idx,
    output logic                       o_fnd,
    output logic [$clog2(DEPTH)-1:0]   o_idx
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] MY_POS = CW'(IDX);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [31:0]   r_key;
    logic          r_match;
    logic          r_fnd;
    logic [IW-1:0] r_idx;

    // Entry store: shifts up on insert, down on delete.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            alist_pkg::OP_INS: begin
                if (MY_POS == i_at) begin
                    r_key <= i_ctrl.key;
                end else if (MY_POS > i_at) begin
                    r_key <= i_left_key;
                end
            end
            alist_pkg::OP_DEL: begin
                if (MY_POS >= i_at) begin
                    r_key <= i_right_key;
                end
            end
            default: begin
            end
        endcase
    end

    // Match flag is taken once per search; the wave then carries the last
    // matching index from cell to cell, one cell per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == alist_pkg::OP_SRCH) begin
            r_match <= (r_key == i_ctrl.key) && (MY_POS < i_count);
        end
        if (i_ctrl.wave) begin
            r_fnd <= i_prev_fnd | r_match;
            r_idx <= r_match ? MY_IDX : i_prev_idx;
        end
    end

    assign o_key = r_key;
    assign o_fnd = r_fnd;
    assign o_idx = r_idx;

endmodule

// ===== hw/rtl/array_list_insert_delete_search.sv =====
// Top level of the array list: request decoding, count, limit register,
// result register and the chain of alist_cell instances. Depends on alist_pkg.
//
// Usage. Requests arrive on the s_axis channel and each produces exactly one
// result item on the m_axis channel. An input item packs req_type, key and
// position; a result item packs status, found, found_index and entry_count.
// The user writes the list limit through i_cfg_wr_en / i_cfg_wr_data only while the
// block is idle (not enforced by the block); it takes effect for the next request.
//
// Timing. Inserts and deletes shift the cells from the shift point upward in the
// cycle the item is accepted; their result is registered and shown on the following
// cycle, and the next item may be accepted in that same cycle, so one insert or
// delete per cycle is sustained while the receiver takes each result. A search
// first latches a match flag in every cell, then a wave walks the chain one cell
// per cycle to find the last match; the done state then registers the result, so
// the wait for a search result is set by the length of the cell chain.
//
// Reset (synchronous, active low) empties the list, sets the limit to 16 and
// drops any pending result. If the receiver stalls, the result is held in
// the output register; one new item is still taken while that result is
// being handed over, otherwise s_axis_tready stays low until it is taken.
module array_list_insert_delete_search #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: list_limit.
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata fields from bit 0: req_type[2:0], key[34:3], position[38:35], zero pad.
    input  logic [39:0] s_axis_tdata,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata fields from bit 0: status[1:0], found[2], found_index[6:3],
    // entry_count[11:7], zero pad.
    output logic [15:0] m_axis_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > 4) ? CW : 4;
    localparam int LW = (CW > 5) ? CW : 5;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);
    localparam logic [CW-1:0] LAST_STEP = CW'(DEPTH - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_step, n_step;
    logic [4:0]    r_limit;
    logic          r_m_valid, n_m_valid;
    logic [15:0]   r_m_data, n_m_data;

    logic                  accept;
    logic [2:0]            req;
    logic [31:0]           key;
    logic [3:0]            position;
    logic [PW-1:0]         pos_ext;
    logic                  pos_ge_count;
    logic [LW-1:0]         eff_limit;
    logic                  full;
    logic [CW-1:0]         at;
    logic [1:0]            status;
    alist_pkg::t_cell_ctrl ctrl;

    logic [31:0]   w_key [DEPTH];
    logic          w_fnd [DEPTH];
    logic [IW-1:0] w_idx [DEPTH];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign req      = s_axis_tdata[2:0];
    assign key      = s_axis_tdata[34:3];
    assign position = s_axis_tdata[38:35];

    assign pos_ext      = PW'(position);
    assign pos_ge_count = pos_ext >= PW'(r_count);
    // The limit saturates at the store depth.
    assign eff_limit    = (LW'(r_limit) > DEPTH_L) ? DEPTH_L : LW'(r_limit);
    assign full         = LW'(r_count) >= eff_limit;

    // Decode the request into a chain operation, the shift point and the new count,
    // build the result for everything but a search, and the search result when done.
    always_comb begin
        ctrl      = '0;
        ctrl.key  = key;
        ctrl.wave = (r_state == S_SEARCH);
        at        = '0;
        status    = alist_pkg::ST_OK;
        n_count   = r_count;
        n_state   = r_state;
        n_step    = r_step;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;

        if (accept) begin
            case (req)
                alist_pkg::REQ_INS_END, alist_pkg::REQ_INS_FRONT,
                alist_pkg::REQ_INS_POS: begin
                    if (full) begin
                        status = alist_pkg::ST_FULL;
                    end else begin
                        ctrl.op = alist_pkg::OP_INS;
                        n_count = r_count + 1'b1;
                        if (req == alist_pkg::REQ_INS_END) begin
                            at = r_count;
                        end else if (req == alist_pkg::REQ_INS_FRONT) begin
                            at = '0;
                        end else if (pos_ge_count) begin
                            // Inserting beyond the list appends at the end.
                            at = r_count;
                        end else begin
                            at = CW'(pos_ext);
                        end
                    end
                end
                alist_pkg::REQ_DEL_END, alist_pkg::REQ_DEL_FRONT,
                alist_pkg::REQ_DEL_POS: begin
                    if (r_count == '0) begin
                        status = alist_pkg::ST_EMPTY;
                    end else if ((req == alist_pkg::REQ_DEL_POS) && pos_ge_count) begin
                        status = alist_pkg::ST_BADIDX;
                    end else begin
                        ctrl.op = alist_pkg::OP_DEL;
                        n_count = r_count - 1'b1;
                        if (req == alist_pkg::REQ_DEL_END) begin
                            at = r_count - 1'b1;
                        end else if (req == alist_pkg::REQ_DEL_FRONT) begin
                            at = '0;
                        end else begin
                            at = CW'(pos_ext);
                        end
                    end
                end
                alist_pkg::REQ_SEARCH: begin
                    ctrl.op = alist_pkg::OP_SRCH;
                end
                default: begin
                end
            endcase

            if (req == alist_pkg::REQ_SEARCH) begin
                n_state = S_SEARCH;
                n_step  = '0;
            end else begin
                n_m_valid = 1'b1;
                n_m_data  = {4'd0, 5'(n_count), 4'd0, 1'b0, status};
            end
        end

        case (r_state)
            S_SEARCH: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // The last cell now holds the outcome of the whole chain.
                n_state   = S_IDLE;
                n_m_valid = 1'b1;
                n_m_data  = {4'd0, 5'(r_count),
                             (w_fnd[DEPTH-1] ? 4'(w_idx[DEPTH-1]) : 4'd0),
                             w_fnd[DEPTH-1], alist_pkg::ST_OK};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_step    <= '0;
            r_limit   <= 5'd16;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_step    <= n_step;
            r_m_valid <= n_m_valid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // The chain: each cell sees its neighbours' entries and the search wave
    // from the cell below it.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0]   left_key;
        logic [31:0]   right_key;
        logic          prev_fnd;
        logic [IW-1:0] prev_idx;

        if (g == 0) begin : g_first
            assign left_key = '0;
            assign prev_fnd = 1'b0;
            assign prev_idx = '0;
        end else begin : g_inner
            assign left_key = w_key[g-1];
            assign prev_fnd = w_fnd[g-1];
            assign prev_idx = w_idx[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key = '0;
        end else begin : g_body
            assign right_key = w_key[g+1];
        end

        alist_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_at        (at),
            .i_count     (r_count),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .o_key       (w_key[g]),
            .i_prev_fnd  (prev_fnd),
            .i_prev_idx  (prev_idx),
            .o_fnd       (w_fnd[g]),
            .o_idx       (w_idx[g])
        );
    end

endmodule
